### design/pfl_pkg.sv
`default_nettype none

package pfl_pkg;

    localparam int MAX_PAGES  = 16;
    localparam int BLOCKS_MAX = 64;
    localparam int PAGE_W     = $clog2(MAX_PAGES);
    localparam int IDX_W      = $clog2(BLOCKS_MAX);
    localparam int LINK_W     = IDX_W + 1;
    localparam int ADDR_W     = PAGE_W + IDX_W;
    localparam int PAGES_W    = PAGE_W + 1;
    localparam int CFG_W      = 7;
    localparam int MEM_DEPTH  = MAX_PAGES * BLOCKS_MAX;

    localparam logic [LINK_W-1:0] END_MARK = LINK_W'(BLOCKS_MAX);

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_NO_MEM    = 2'd1,
        STATUS_NOT_OWNED = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        FS_INIT,
        FS_IDLE,
        FS_OPEN,
        FS_ISSUE,
        FS_POP
    } fsm_state_t;

    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_INC,
        CNT_DEC,
        CNT_CLR
    } cnt_cmd_t;

    typedef struct packed {
        logic [PAGE_W-1:0] page;
        logic              head_we;
        logic [LINK_W-1:0] head_val;
        cnt_cmd_t          cnt_cmd;
        logic              open_inc;
    } pt_upd_t;

    typedef struct packed {
        logic [LINK_W-1:0]  sel_head;
        logic               sel_full;
        logic               sel_open;
        logic               found;
        logic [PAGE_W-1:0]  found_page;
        logic [PAGES_W-1:0] pages_open;
    } pt_stat_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [LINK_W-1:0] wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } ram_req_t;

    // clamp the page size register to 1 .. BLOCKS_MAX
    function automatic logic [LINK_W-1:0] eff_blocks(input logic [CFG_W-1:0] cfg);
        logic [LINK_W-1:0] n;
        if (cfg == '0) begin
            n = LINK_W'(1);
        end else if (cfg > CFG_W'(BLOCKS_MAX)) begin
            n = LINK_W'(BLOCKS_MAX);
        end else begin
            n = LINK_W'(cfg);
        end
        return n;
    endfunction

endpackage

`default_nettype wire

### design/pfl_link_ram.sv
`default_nettype none

module pfl_link_ram
    import pfl_pkg::*;
(
    input  wire               aclk,
    input  wire ram_req_t     req,
    output logic [LINK_W-1:0] rdata
);

    logic [LINK_W-1:0] mem [MEM_DEPTH];
    logic [LINK_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (req.we) begin
            mem[req.waddr] <= req.wdata;
        end
        if (req.re) begin
            rdata_reg <= mem[req.raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### design/pfl_page_table.sv
`default_nettype none

module pfl_page_table
    import pfl_pkg::*;
(
    input  wire               aclk,
    input  wire               aresetn,
    input  wire  [LINK_W-1:0] eff,
    input  wire  [PAGE_W-1:0] rd_page,
    input  wire  pt_upd_t     upd,
    output pt_stat_t          stat
);

    logic [LINK_W-1:0]  head_reg  [MAX_PAGES];
    logic [LINK_W-1:0]  count_reg [MAX_PAGES];
    logic [PAGES_W-1:0] pages_open_reg;

    logic [MAX_PAGES-1:0] full;
    logic [MAX_PAGES-1:0] avail;
    logic                 found;
    logic [PAGE_W-1:0]    found_page;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < MAX_PAGES; i++) begin
                head_reg[i]  <= '0;
                count_reg[i] <= '0;
            end
            pages_open_reg <= PAGES_W'(1);
        end else begin
            if (upd.head_we) begin
                head_reg[upd.page] <= upd.head_val;
            end
            case (upd.cnt_cmd)
                CNT_INC: count_reg[upd.page] <= count_reg[upd.page] + LINK_W'(1);
                CNT_DEC: begin
                    // saturate at zero
                    if (count_reg[upd.page] != '0) begin
                        count_reg[upd.page] <= count_reg[upd.page] - LINK_W'(1);
                    end
                end
                CNT_CLR: count_reg[upd.page] <= '0;
                default: ;
            endcase
            if (upd.open_inc) begin
                pages_open_reg <= pages_open_reg + PAGES_W'(1);
            end
        end
    end

    always_comb begin
        for (int i = 0; i < MAX_PAGES; i++) begin
            full[i]  = (count_reg[i] >= eff) || (head_reg[i] >= END_MARK);
            avail[i] = (PAGES_W'(i) < pages_open_reg) && !full[i];
        end
    end

    // lowest open page that still has room
    always_comb begin
        found      = 1'b0;
        found_page = '0;
        for (int i = MAX_PAGES - 1; i >= 0; i--) begin
            if (avail[i]) begin
                found      = 1'b1;
                found_page = PAGE_W'(i);
            end
        end
    end

    always_comb begin
        stat.sel_head   = head_reg[rd_page];
        stat.sel_full   = full[rd_page];
        stat.sel_open   = {1'b0, rd_page} < pages_open_reg;
        stat.found      = found;
        stat.found_page = found_page;
        stat.pages_open = pages_open_reg;
    end

endmodule

`default_nettype wire

### design/pfl_ctrl.sv
`default_nettype none

module pfl_ctrl
    import pfl_pkg::*;
(
    input  wire               aclk,
    input  wire               aresetn,
    input  wire               s_valid,
    output logic              s_ready,
    input  wire               s_operation,
    input  wire  [PAGE_W-1:0] s_block_page,
    input  wire  [IDX_W-1:0]  s_block_index,
    output logic              m_valid,
    input  wire               m_ready,
    output logic [1:0]        m_status,
    output logic [PAGE_W-1:0] m_result_page,
    output logic [IDX_W-1:0]  m_result_index,
    input  wire  [LINK_W-1:0] eff,
    input  wire  pt_stat_t    pt_stat,
    output logic [PAGE_W-1:0] pt_rd_page,
    output pt_upd_t           pt_upd,
    output ram_req_t          ram_req,
    input  wire  [LINK_W-1:0] ram_rdata
);

    fsm_state_t        state_reg, state_next;
    logic [PAGE_W-1:0] pg_reg, pg_next;
    logic [IDX_W-1:0]  head_reg, head_next;
    logic [IDX_W-1:0]  cnt_reg, cnt_next;
    logic [LINK_W-1:0] sweep_n_reg, sweep_n_next;
    logic              m_valid_reg, m_valid_next;
    status_t           m_status_reg, m_status_next;
    logic [PAGE_W-1:0] m_page_reg, m_page_next;
    logic [IDX_W-1:0]  m_index_reg, m_index_next;

    logic              out_free;
    logic              in_xfer;
    logic              is_alloc;
    logic              can_open;
    logic              free_ok;
    logic [LINK_W-1:0] cnt_p1;
    logic              sweep_last;
    logic [LINK_W-1:0] sweep_wdata;

    assign out_free    = !m_valid_reg || m_ready;
    assign s_ready     = (state_reg == FS_IDLE) && out_free;
    assign in_xfer     = s_valid && s_ready;
    assign is_alloc    = (s_operation == OP_ALLOC);
    assign can_open    = pt_stat.pages_open < PAGES_W'(MAX_PAGES);
    assign free_ok     = pt_stat.sel_open && ({1'b0, s_block_index} < eff);
    assign cnt_p1      = {1'b0, cnt_reg} + LINK_W'(1);
    assign sweep_last  = (cnt_p1 == sweep_n_reg);
    assign sweep_wdata = sweep_last ? END_MARK : cnt_p1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= FS_INIT;
            pg_reg      <= '0;
            cnt_reg     <= '0;
            sweep_n_reg <= END_MARK;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            pg_reg      <= pg_next;
            cnt_reg     <= cnt_next;
            sweep_n_reg <= sweep_n_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        head_reg     <= head_next;
        m_status_reg <= m_status_next;
        m_page_reg   <= m_page_next;
        m_index_reg  <= m_index_next;
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            FS_INIT: begin
                if (sweep_last) state_next = FS_IDLE;
            end
            FS_IDLE: begin
                if (in_xfer && is_alloc) begin
                    if (pt_stat.found) begin
                        state_next = FS_POP;
                    end else if (can_open) begin
                        state_next = FS_OPEN;
                    end
                end
            end
            FS_OPEN: begin
                if (sweep_last) state_next = FS_ISSUE;
            end
            FS_ISSUE: state_next = FS_POP;
            FS_POP: begin
                if (out_free) state_next = FS_IDLE;
            end
            default: state_next = FS_IDLE;
        endcase
    end

    always_comb begin
        pg_next       = pg_reg;
        head_next     = head_reg;
        cnt_next      = cnt_reg;
        sweep_n_next  = sweep_n_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_status_next = m_status_reg;
        m_page_next   = m_page_reg;
        m_index_next  = m_index_reg;

        pt_rd_page      = pg_reg;
        pt_upd.page     = pg_reg;
        pt_upd.head_we  = 1'b0;
        pt_upd.head_val = ram_rdata;
        pt_upd.cnt_cmd  = CNT_HOLD;
        pt_upd.open_inc = 1'b0;

        ram_req.we    = 1'b0;
        ram_req.waddr = {pg_reg, cnt_reg};
        ram_req.wdata = sweep_wdata;
        ram_req.re    = 1'b0;
        ram_req.raddr = {pg_reg, pt_stat.sel_head[IDX_W-1:0]};

        case (state_reg)
            FS_INIT, FS_OPEN: begin
                // lay down the chain 0,1,2,... of a fresh page
                ram_req.we = 1'b1;
                cnt_next   = cnt_reg + IDX_W'(1);
            end
            FS_IDLE: begin
                pt_rd_page = is_alloc ? pt_stat.found_page : s_block_page;
                if (in_xfer) begin
                    if (is_alloc) begin
                        if (pt_stat.found) begin
                            pg_next       = pt_stat.found_page;
                            head_next     = pt_stat.sel_head[IDX_W-1:0];
                            ram_req.re    = 1'b1;
                            ram_req.raddr = {pt_stat.found_page, pt_stat.sel_head[IDX_W-1:0]};
                        end else if (can_open) begin
                            pg_next         = pt_stat.pages_open[PAGE_W-1:0];
                            cnt_next        = '0;
                            sweep_n_next    = eff;
                            pt_upd.page     = pt_stat.pages_open[PAGE_W-1:0];
                            pt_upd.head_we  = 1'b1;
                            pt_upd.head_val = '0;
                            pt_upd.cnt_cmd  = CNT_CLR;
                            pt_upd.open_inc = 1'b1;
                        end else begin
                            m_valid_next  = 1'b1;
                            m_status_next = STATUS_NO_MEM;
                            m_page_next   = '0;
                            m_index_next  = '0;
                        end
                    end else begin
                        m_valid_next = 1'b1;
                        m_page_next  = '0;
                        m_index_next = '0;
                        if (free_ok) begin
                            m_status_next   = STATUS_OK;
                            ram_req.we      = 1'b1;
                            ram_req.waddr   = {s_block_page, s_block_index};
                            // a full page starts a new list
                            ram_req.wdata   = pt_stat.sel_full ? END_MARK : pt_stat.sel_head;
                            pt_upd.page     = s_block_page;
                            pt_upd.head_we  = 1'b1;
                            pt_upd.head_val = {1'b0, s_block_index};
                            pt_upd.cnt_cmd  = CNT_DEC;
                        end else begin
                            m_status_next = STATUS_NOT_OWNED;
                        end
                    end
                end
            end
            FS_ISSUE: begin
                head_next  = pt_stat.sel_head[IDX_W-1:0];
                ram_req.re = 1'b1;
            end
            FS_POP: begin
                if (out_free) begin
                    pt_upd.head_we  = 1'b1;
                    pt_upd.head_val = ram_rdata;
                    pt_upd.cnt_cmd  = CNT_INC;
                    m_valid_next    = 1'b1;
                    m_status_next   = STATUS_OK;
                    m_page_next     = pg_reg;
                    m_index_next    = head_reg;
                end
            end
            default: ;
        endcase
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = m_status_reg;
    assign m_result_page  = m_page_reg;
    assign m_result_index = m_index_reg;

endmodule

`default_nettype wire

### design/paged_free_list_block_allocator_core.sv
`default_nettype none

// Paged fixed-size block allocator: up to 16 pages of blocks_per_page blocks, each page with a
// LIFO free list kept in a 1024 x 7 link memory plus per-page head and occupancy registers.
// A free's result is registered in the cycle after the transfer; an allocate reads the link
// memory at the transfer, then in the pop state, once the output is free, pops the head into
// the result register. An allocate that has to open a new page first writes that page's chain
// of clamped blocks_per_page (1 to 64) entries into the link memory one entry per cycle. After
// reset the block writes page 0's chain of 64 entries and takes no transfer until then;
// configuration writes are taken at any time. One request is in flight at a time.
module paged_free_list_block_allocator_core
    import pfl_pkg::*;
(
    input  wire               aclk,
    input  wire               aresetn,
    input  wire               cfg_wr_en,
    input  wire  [CFG_W-1:0]  cfg_wr_data,
    input  wire               s_valid,
    output logic              s_ready,
    input  wire               s_operation,
    input  wire  [PAGE_W-1:0] s_block_page,
    input  wire  [IDX_W-1:0]  s_block_index,
    output logic              m_valid,
    input  wire               m_ready,
    output logic [1:0]        m_status,
    output logic [PAGE_W-1:0] m_result_page,
    output logic [IDX_W-1:0]  m_result_index
);

    logic [CFG_W-1:0]  blocks_per_page_reg;
    logic [LINK_W-1:0] eff;
    logic [PAGE_W-1:0] pt_rd_page;
    pt_upd_t           pt_upd;
    pt_stat_t          pt_stat;
    ram_req_t          ram_req;
    logic [LINK_W-1:0] ram_rdata;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            blocks_per_page_reg <= CFG_W'(BLOCKS_MAX);
        end else if (cfg_wr_en) begin
            blocks_per_page_reg <= cfg_wr_data;
        end
    end

    assign eff = eff_blocks(blocks_per_page_reg);

    pfl_page_table u_page_table (
        .aclk    (aclk),
        .aresetn (aresetn),
        .eff     (eff),
        .rd_page (pt_rd_page),
        .upd     (pt_upd),
        .stat    (pt_stat)
    );

    pfl_link_ram u_link_ram (
        .aclk  (aclk),
        .req   (ram_req),
        .rdata (ram_rdata)
    );

    pfl_ctrl u_ctrl (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_operation    (s_operation),
        .s_block_page   (s_block_page),
        .s_block_index  (s_block_index),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_result_page  (m_result_page),
        .m_result_index (m_result_index),
        .eff            (eff),
        .pt_stat        (pt_stat),
        .pt_rd_page     (pt_rd_page),
        .pt_upd         (pt_upd),
        .ram_req        (ram_req),
        .ram_rdata      (ram_rdata)
    );

    a_pages_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (pt_stat.pages_open != '0) && (pt_stat.pages_open <= PAGES_W'(MAX_PAGES)))
        else $error("open page count out of range");

    a_pages_step: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |->
            (pt_stat.pages_open == $past(pt_stat.pages_open)) ||
            (pt_stat.pages_open == $past(pt_stat.pages_open) + PAGES_W'(1)))
        else $error("open page count moved by more than one");

    a_no_rw_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        (ram_req.we && ram_req.re) |-> (ram_req.waddr != ram_req.raddr))
        else $error("link memory read and write hit the same entry");

    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status != STATUS_OK)) |->
            ((m_result_page == '0) && (m_result_index == '0)))
        else $error("failed request carries a block address");

endmodule

`default_nettype wire

### test/tb_paged_free_list_block_allocator_core.sv
`timescale 1ns / 100ps

module tb_paged_free_list_block_allocator_core;
    import pfl_pkg::*;

    localparam int RUN_LIMIT     = 500000;
    localparam int SETTLE_CYCLES = 80;
    localparam int HOLD_CYCLES   = 400;

    typedef struct packed {
        status_t           status;
        logic [PAGE_W-1:0] page;
        logic [IDX_W-1:0]  index;
    } grant_t;

    typedef struct packed {
        logic [PAGE_W-1:0] page;
        logic [IDX_W-1:0]  index;
    } block_ref_t;

    logic              aclk          = 1'b0;
    logic              aresetn       = 1'b0;
    logic              cfg_wr_en     = 1'b0;
    logic [CFG_W-1:0]  cfg_wr_data   = '0;
    logic              s_valid       = 1'b0;
    logic              s_ready;
    logic              s_operation   = OP_ALLOC;
    logic [PAGE_W-1:0] s_block_page  = '0;
    logic [IDX_W-1:0]  s_block_index = '0;
    logic              m_valid;
    logic              m_ready       = 1'b0;
    logic [1:0]        m_status;
    logic [PAGE_W-1:0] m_result_page;
    logic [IDX_W-1:0]  m_result_index;

    // allocator state as the testbench sees it
    logic [LINK_W-1:0] free_link [MEM_DEPTH];
    logic [LINK_W-1:0] page_head [MAX_PAGES];
    logic [LINK_W-1:0] page_used [MAX_PAGES];
    int                pages_opened;
    logic [CFG_W-1:0]  blocks_per_page_reg;

    grant_t     expected_grants[$];
    block_ref_t held_blocks[$];
    grant_t     grant_now;
    grant_t     grant_want;
    block_ref_t held_now;

    int err_count      = 0;
    int cycle_count    = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_left      = 0;
    logic hold_toggle  = 1'b0;
    logic hold_taken   = 1'b0;

    paged_free_list_block_allocator_core dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_operation    (s_operation),
        .s_block_page   (s_block_page),
        .s_block_index  (s_block_index),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_result_page  (m_result_page),
        .m_result_index (m_result_index)
    );

    always #4 aclk = ~aclk;

    function automatic int page_size();
        if (blocks_per_page_reg == '0) begin
            return 1;
        end else if (int'(blocks_per_page_reg) > BLOCKS_MAX) begin
            return BLOCKS_MAX;
        end
        return int'(blocks_per_page_reg);
    endfunction

    function automatic bit page_is_full(input int pg);
        return (int'(page_used[pg]) >= page_size()) || (page_head[pg] >= END_MARK);
    endfunction

    function automatic void open_page_chain(input int pg);
        int n;
        int i;
        n = page_size();
        for (i = 0; i + 1 < n; i++) begin
            free_link[pg * BLOCKS_MAX + i] = LINK_W'(i + 1);
        end
        free_link[pg * BLOCKS_MAX + n - 1] = END_MARK;
        page_head[pg] = '0;
        page_used[pg] = '0;
    endfunction

    function automatic void reset_allocator_state();
        int i;
        for (i = 0; i < MEM_DEPTH; i++) free_link[i] = '0;
        for (i = 0; i < MAX_PAGES; i++) begin
            page_head[i] = '0;
            page_used[i] = '0;
        end
        blocks_per_page_reg = CFG_W'(BLOCKS_MAX);
        open_page_chain(0);
        pages_opened = 1;
    endfunction

    function automatic grant_t predict_grant(input logic op, input logic [PAGE_W-1:0] pg,
                                             input logic [IDX_W-1:0] idx);
        grant_t g;
        int sel;
        int p;
        logic [LINK_W-1:0] top;
        g.status = STATUS_OK;
        g.page   = '0;
        g.index  = '0;
        if (op == OP_ALLOC) begin
            sel = -1;
            for (p = pages_opened - 1; p >= 0; p--) begin
                if (!page_is_full(p)) sel = p;
            end
            if (sel < 0 && pages_opened < MAX_PAGES) begin
                sel = pages_opened;
                open_page_chain(sel);
                pages_opened++;
            end
            if (sel < 0) begin
                g.status = STATUS_NO_MEM;
            end else begin
                top = page_head[sel];
                page_head[sel] = free_link[sel * BLOCKS_MAX + int'(top)];
                page_used[sel] = page_used[sel] + 1'b1;
                g.page  = PAGE_W'(sel);
                g.index = top[IDX_W-1:0];
            end
        end else if (int'(pg) >= pages_opened || int'(idx) >= page_size()) begin
            g.status = STATUS_NOT_OWNED;
        end else begin
            // a block freed into a full page starts a fresh list
            free_link[int'(pg) * BLOCKS_MAX + int'(idx)] =
                page_is_full(int'(pg)) ? END_MARK : page_head[pg];
            page_head[pg] = {1'b0, idx};
            if (page_used[pg] != '0) page_used[pg] = page_used[pg] - 1'b1;
        end
        return g;
    endfunction

    task automatic report_mismatch(input string msg);
        if (err_count < 40) $display("mismatch at cycle %0d: %s", cycle_count, msg);
        err_count++;
    endtask

    // results are checked before new transfers are predicted, in one process
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_grants.size() == 0) begin
                    report_mismatch($sformatf("result with nothing pending: status %0d",
                                              m_status));
                end else begin
                    grant_want = expected_grants.pop_front();
                    if (m_status !== grant_want.status)
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  m_status, grant_want.status));
                    if (m_result_page !== grant_want.page)
                        report_mismatch($sformatf("page %0d, expected %0d",
                                                  m_result_page, grant_want.page));
                    if (m_result_index !== grant_want.index)
                        report_mismatch($sformatf("index %0d, expected %0d",
                                                  m_result_index, grant_want.index));
                end
            end
            if (s_valid && s_ready) begin
                grant_now = predict_grant(s_operation, s_block_page, s_block_index);
                expected_grants.push_back(grant_now);
                if (s_operation == OP_ALLOC && grant_now.status == STATUS_OK) begin
                    held_now.page  = grant_now.page;
                    held_now.index = grant_now.index;
                    held_blocks.push_back(held_now);
                end
            end
        end
    end

    // receiver: random stalls, plus a long hold-off on request
    always @(posedge aclk) begin
        if (hold_left != 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_toggle != hold_taken) begin
            m_ready    <= 1'b0;
            hold_left  <= HOLD_CYCLES;
            hold_taken <= hold_toggle;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT) begin
            $display("paged_free_list_block_allocator_core regression: fail");
            $finish;
        end
    end

    task automatic send_request(input logic op, input logic [PAGE_W-1:0] pg,
                                input logic [IDX_W-1:0] idx);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < send_idle_pct) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_operation   <= op;
        s_block_page  <= pg;
        s_block_index <= idx;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic wait_until_settled(input int extra);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (expected_grants.size() != 0) @(posedge aclk);
        repeat (extra) @(posedge aclk);
    endtask

    task automatic set_page_size(input logic [CFG_W-1:0] value);
        wait_until_settled(4);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        blocks_per_page_reg = value;
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    // allocations at alloc_pct, else mostly frees of blocks handed out earlier, the rest arbitrary frees
    task automatic run_mixed_traffic(input int count, input int alloc_pct);
        int n;
        int k;
        block_ref_t b;
        for (n = 0; n < count; n++) begin
            if ($urandom_range(99) < alloc_pct) begin
                send_request(OP_ALLOC, PAGE_W'($urandom), IDX_W'($urandom));
            end else if (held_blocks.size() != 0 && $urandom_range(99) < 80) begin
                k = $urandom_range(held_blocks.size() - 1);
                b = held_blocks[k];
                held_blocks.delete(k);
                send_request(OP_FREE, b.page, b.index);
            end else begin
                send_request(OP_FREE, PAGE_W'($urandom), IDX_W'($urandom));
            end
        end
    endtask

    task automatic test_directed_cases();
        set_idling(0, 0);
        send_request(OP_ALLOC, 4'd15, 6'd63);
        send_request(OP_ALLOC, 4'd0, 6'd0);
        send_request(OP_ALLOC, 4'd7, 6'd42);
        // lifo: the freed block comes straight back
        send_request(OP_FREE, 4'd0, 6'd1);
        send_request(OP_ALLOC, 4'd0, 6'd0);
        // pages that were never opened, then a page 0 block that was never handed out
        send_request(OP_FREE, 4'd15, 6'd0);
        send_request(OP_FREE, 4'd1, 6'd0);
        send_request(OP_FREE, 4'd0, 6'd63);
        send_request(OP_ALLOC, 4'd0, 6'd0);
        set_page_size(7'd2);
        // index past the page size
        send_request(OP_FREE, 4'd0, 6'd2);
        // page 0 over the new size, so new pages open
        send_request(OP_ALLOC, 4'd0, 6'd0);
        send_request(OP_ALLOC, 4'd0, 6'd0);
        send_request(OP_ALLOC, 4'd0, 6'd0);
        // free into a full page
        send_request(OP_FREE, 4'd1, 6'd0);
        send_request(OP_ALLOC, 4'd0, 6'd0);
        send_request(OP_ALLOC, 4'd0, 6'd0);
        // double frees drive the count down to zero and hold it there
        send_request(OP_FREE, 4'd2, 6'd0);
        send_request(OP_FREE, 4'd2, 6'd0);
        send_request(OP_FREE, 4'd2, 6'd1);
        send_request(OP_FREE, 4'd2, 6'd1);
        send_request(OP_ALLOC, 4'd0, 6'd0);
    endtask

    task automatic test_page_size_sweep();
        set_page_size(7'd7);
        set_idling(0, 0);
        run_mixed_traffic(350, 55);
        set_page_size(7'd127);
        set_idling(58, 0);
        run_mixed_traffic(300, 55);
        set_page_size(7'd33);
        set_idling(0, 58);
        run_mixed_traffic(280, 60);
        set_page_size(7'd64);
        set_idling(14, 14);
        run_mixed_traffic(250, 50);
    endtask

    task automatic test_output_backpressure();
        set_page_size(7'd20);
        set_idling(0, 0);
        hold_toggle <= ~hold_toggle;
        run_mixed_traffic(40, 60);
    endtask

    task automatic test_exhaust_pages();
        set_page_size(7'd1);
        set_idling(14, 14);
        run_mixed_traffic(200, 80);
        set_page_size(7'd0);
        set_idling(0, 0);
        run_mixed_traffic(100, 50);
        set_page_size(7'd65);
        set_idling(0, 58);
        run_mixed_traffic(150, 35);
    endtask

    initial begin
        reset_allocator_state();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed_cases();
        test_page_size_sweep();
        test_output_backpressure();
        test_exhaust_pages();
        wait_until_settled(SETTLE_CYCLES);
        if (expected_grants.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_grants.size()));
        if (err_count == 0) begin
            $display("paged_free_list_block_allocator_core regression: pass");
        end else begin
            $display("paged_free_list_block_allocator_core regression: fail");
        end
        $finish;
    end

endmodule

### paged_free_list_block_allocator_core.f
design/pfl_pkg.sv
design/pfl_link_ram.sv
design/pfl_page_table.sv
design/pfl_ctrl.sv
design/paged_free_list_block_allocator_core.sv
test/tb_paged_free_list_block_allocator_core.sv
